// ----- design/bis_pkg.sv -----
// Package for the bounded index sampler: widths, register indexes and the threshold table.
// It has no dependencies and is used by every module of the block.
`default_nettype none

package bis_pkg;

    localparam int MAX_SET   = 1024;
    localparam int WORD_W    = 16;
    localparam int REM_W     = WORD_W + 1;
    localparam int BOUND_W   = $clog2(MAX_SET + 1);
    localparam int ROM_AW    = BOUND_W;
    localparam int IDX_W     = 10;
    localparam int SET_W     = 11;
    localparam int BUDGET_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int PROD_W    = WORD_W + BOUND_W;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WORD_BUDGET = CFG_IDX_W'(1);

    localparam logic [BOUND_W-1:0]  SET_SIZE_RESET    = BOUND_W'(MAX_SET < 1024 ? MAX_SET : 1024);
    localparam logic [BUDGET_W-1:0] WORD_BUDGET_RESET = BUDGET_W'(4096);

    typedef logic [WORD_W-1:0] thr_word_t;
    typedef thr_word_t thr_rom_t [0:MAX_SET];

    // Entry a holds 2^16 mod a, found by restoring long division; entry 0 holds zero.
    function automatic thr_rom_t build_thr_rom();
        thr_rom_t         t;
        logic [REM_W-1:0] r;
        t[0] = '0;
        for (int a = 1; a <= MAX_SET; a++) begin
            r = '0;
            for (int i = WORD_W; i >= 0; i--) begin
                r = {r[REM_W-2:0], (i == WORD_W)};
                if (r >= REM_W'(a)) begin
                    r = r - REM_W'(a);
                end
            end
            t[a] = r[WORD_W-1:0];
        end
        return t;
    endfunction

    localparam thr_rom_t THR_ROM = build_thr_rom();

endpackage

`default_nettype wire

// ----- design/bounded_index_sampler_top.sv -----
// Top level of the bounded index sampler: run control, multiply, threshold compare and
// output register. Depends on bis_pkg and bis_thr_rom.
//
// Usage:
// Each transfer on the s_ channel carries one random 16-bit word. The word is multiplied
// by the current bound; when the low half of the product falls below 2^16 mod bound the
// word is rejected and produces nothing, otherwise the high half leaves on the m_ channel
// as the index for the current position. The bound starts at set_size and falls by one
// per index, so a run yields set_size indexes; the last one has m_last set. A run that
// has used word_budget words ends with a result that has m_failed and m_last set, and a
// new run begins. One word is taken every cycle while s_ready is high; a result is shown
// in the cycle after its word is taken. The threshold ROM has two read ports: one
// prefetches the entry for the next lower bound, the other holds the entry for set_size.
// After reset and after each write of set_size, s_ready stays low while the ROM outputs
// settle. When the receiver stalls, the result waits in the output register and s_ready
// drops until it is taken.
`default_nettype none

module bounded_index_sampler_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bis_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bis_pkg::WORD_W-1:0]    s_random_word,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bis_pkg::IDX_W-1:0]     m_index,
    output logic      [bis_pkg::IDX_W-1:0]     m_position,
    output logic                               m_last,
    output logic                               m_failed
);

    logic [bis_pkg::BOUND_W-1:0]  set_size_reg, set_size_next;
    logic [bis_pkg::BUDGET_W-1:0] budget_reg, budget_next;
    logic [bis_pkg::BOUND_W-1:0]  bound_reg, bound_next;
    logic [bis_pkg::BUDGET_W-1:0] used_reg, used_next;
    logic [bis_pkg::WORD_W-1:0]   thr_cur_reg, thr_cur_next;
    logic [1:0]                   stall_reg, stall_next;
    logic                         m_valid_reg, m_valid_next;
    logic [bis_pkg::IDX_W-1:0]    m_index_reg;
    logic [bis_pkg::IDX_W-1:0]    m_position_reg;
    logic                         m_last_reg;
    logic                         m_failed_reg;

    logic [bis_pkg::WORD_W-1:0]   thr_dec;
    logic [bis_pkg::WORD_W-1:0]   thr_set;
    logic [bis_pkg::ROM_AW-1:0]   addr_a;
    logic [bis_pkg::PROD_W-1:0]   prod;
    logic [bis_pkg::SET_W-1:0]    cfg_set_raw;
    logic [bis_pkg::BOUND_W-1:0]  cfg_set;
    logic                         set_wr;
    logic                         budget_wr;
    logic                         accept;
    logic                         fail;
    logic                         reject;
    logic                         last_pos;
    logic                         emit;
    logic                         restart;
    logic                         dec;

    bis_thr_rom u_thr_rom (
        .aclk   (aclk),
        .addr_a (addr_a),
        .addr_b (set_size_reg),
        .q_a    (thr_dec),
        .q_b    (thr_set)
    );

    assign s_ready   = (stall_reg == 2'd0) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign prod      = bis_pkg::PROD_W'(s_random_word) * bis_pkg::PROD_W'(bound_reg);
    assign fail      = used_reg >= budget_reg;
    assign reject    = prod[bis_pkg::WORD_W-1:0] < thr_cur_reg;
    assign last_pos  = bound_reg == bis_pkg::BOUND_W'(1);
    assign emit      = accept && (fail || !reject);
    assign restart   = accept && (fail || (!reject && last_pos));
    assign dec       = accept && !fail && !reject && !last_pos;
    assign set_wr    = cfg_wr_en && (cfg_index == bis_pkg::REG_SET_SIZE);
    assign budget_wr = cfg_wr_en && (cfg_index == bis_pkg::REG_WORD_BUDGET);
    assign addr_a    = bound_next - bis_pkg::ROM_AW'(1);

    always_comb begin
        cfg_set_raw = cfg_wdata[bis_pkg::SET_W-1:0];
        if (cfg_set_raw == '0) begin
            cfg_set = bis_pkg::BOUND_W'(1);
        end else if (32'(cfg_set_raw) > bis_pkg::MAX_SET) begin
            cfg_set = bis_pkg::BOUND_W'(bis_pkg::MAX_SET);
        end else begin
            cfg_set = bis_pkg::BOUND_W'(cfg_set_raw);
        end
    end

    always_comb begin
        set_size_next = set_size_reg;
        budget_next   = budget_reg;
        bound_next    = bound_reg;
        used_next     = used_reg;
        thr_cur_next  = thr_cur_reg;
        stall_next    = (stall_reg != 2'd0) ? stall_reg - 2'd1 : stall_reg;
        if (budget_wr) begin
            budget_next = cfg_wdata[bis_pkg::BUDGET_W-1:0];
        end
        if (stall_reg != 2'd0) begin
            thr_cur_next = thr_set;
        end
        if (set_wr) begin
            set_size_next = cfg_set;
            bound_next    = cfg_set;
            used_next     = '0;
            stall_next    = 2'd2;
        end else if (restart) begin
            bound_next   = set_size_reg;
            used_next    = '0;
            thr_cur_next = thr_set;
        end else if (accept) begin
            used_next = used_reg + bis_pkg::BUDGET_W'(1);
            if (dec) begin
                bound_next   = bound_reg - bis_pkg::BOUND_W'(1);
                thr_cur_next = thr_dec;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg <= bis_pkg::SET_SIZE_RESET;
            budget_reg   <= bis_pkg::WORD_BUDGET_RESET;
            bound_reg    <= bis_pkg::SET_SIZE_RESET;
            used_reg     <= '0;
            stall_reg    <= 2'd2;
            m_valid_reg  <= 1'b0;
        end else begin
            set_size_reg <= set_size_next;
            budget_reg   <= budget_next;
            bound_reg    <= bound_next;
            used_reg     <= used_next;
            stall_reg    <= stall_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        thr_cur_reg <= thr_cur_next;
        if (emit) begin
            m_index_reg    <= fail ? '0 : prod[bis_pkg::WORD_W +: bis_pkg::IDX_W];
            m_position_reg <= bis_pkg::IDX_W'(set_size_reg - bound_reg);
            m_last_reg     <= fail || last_pos;
            m_failed_reg   <= fail;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_index    = m_index_reg;
    assign m_position = m_position_reg;
    assign m_last     = m_last_reg;
    assign m_failed   = m_failed_reg;

endmodule

`default_nettype wire

// ----- design/bis_thr_rom.sv -----
// Dual-read threshold ROM with registered outputs.
// Contents come from bis_pkg::THR_ROM.
`default_nettype none

module bis_thr_rom (
    input  wire logic                       aclk,
    input  wire logic [bis_pkg::ROM_AW-1:0] addr_a,
    input  wire logic [bis_pkg::ROM_AW-1:0] addr_b,
    output logic      [bis_pkg::WORD_W-1:0] q_a,
    output logic      [bis_pkg::WORD_W-1:0] q_b
);

    logic [bis_pkg::WORD_W-1:0] q_a_reg;
    logic [bis_pkg::WORD_W-1:0] q_b_reg;

    always_ff @(posedge aclk) begin
        q_a_reg <= bis_pkg::THR_ROM[addr_a];
        q_b_reg <= bis_pkg::THR_ROM[addr_b];
    end

    assign q_a = q_a_reg;
    assign q_b = q_b_reg;

endmodule

`default_nettype wire

// ----- design/bis_checker.sv -----
// Port-level checks for the bounded index sampler, bound to the top level.
// Depends on bis_pkg and bounded_index_sampler_top.
`default_nettype none

module bis_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_wr_en,
    input wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [bis_pkg::IDX_W-1:0]     m_index,
    input wire logic                          m_last,
    input wire logic                          m_failed
);

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index) && $stable(m_last))
        else $error("A stalled result changed before its transfer.");

    a_fail_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> m_last)
        else $error("A failed result did not end the run.");

    a_last_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_index == '0)
        else $error("A result that ends the run carries a nonzero index.");

    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("The input was ready right after reset.");

    a_set_write_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == bis_pkg::REG_SET_SIZE |=> !s_ready)
        else $error("The input was ready right after a set size write.");

endmodule

bind bounded_index_sampler_top bis_checker u_bis_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_index   (m_index),
    .m_last    (m_last),
    .m_failed  (m_failed)
);

`default_nettype wire
